[sv/gov_pkg.sv]
// Package for the ordered grid walk block: word types, widths, defaults.
// No dependencies; used by grid_ordered_visit_path_length.
package gov_pkg;

   localparam int MAX_DIM_DEFAULT     = 64;
   localparam int HEIGHT_BITS_DEFAULT = 16;
   localparam int DIM_REG_BITS        = 7;
   localparam int STEP_BITS           = 25;
   localparam int ADDR_BITS           = 3;
   localparam int DATA_BITS           = 32;

   localparam logic [ADDR_BITS-1:0] REG_GRID_ROWS = 3'd0;
   localparam logic [ADDR_BITS-1:0] REG_GRID_COLS = 3'd4;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_RUN  = 1'b1;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNREACHABLE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [5:0]  cell_row;
      logic [5:0]  cell_col;
      logic [15:0] cell_value;
   } req_word_type;

   typedef struct packed {
      logic                 walk_status;
      logic [STEP_BITS-1:0] total_steps;
   } rsp_word_type;

endpackage

[sv/grid_ordered_visit_path_length.sv]
// Top level of the ordered grid walk: grid store, target search, BFS sequencer.
// Depends on gov_pkg for word types, register addresses and widths.
//
// A load word writes one grid cell and leaves the block idle. A run word
// keeps the block busy (req_stall high) until its result is formed. The run
// repeats a search pass and a leg: the search pass reads every active cell
// once from the grid memory; each leg first clears the visited memory one
// entry a cycle (all entries: MAX_DIM rounded up to a power of two, squared,
// 4096 by default), then runs a breadth-first search in which one shared
// neighbor unit examines the four neighbors of each dequeued cell in turn.
// A leg whose target is the current cell skips the clear and the search. The
// one result word waits in an output register; a run that finishes while an
// earlier result is still held waits for it to be taken. Loads outside the
// store are dropped and the sum saturates at 2^25-1.
module grid_ordered_visit_path_length #(
   parameter int MAX_DIM     = gov_pkg::MAX_DIM_DEFAULT,
   parameter int HEIGHT_BITS = gov_pkg::HEIGHT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gov_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gov_pkg::rsp_word_type          rsp_word,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gov_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [gov_pkg::DATA_BITS-1:0]  pwdata,
   output logic [gov_pkg::DATA_BITS-1:0]  prdata,
   output logic                           pready
);

   localparam int DIM_BITS = $clog2(MAX_DIM);
   localparam int CNT_BITS = DIM_BITS + 1;
   localparam int IDX_BITS = 2 * DIM_BITS;
   localparam int DEPTH    = 1 << IDX_BITS;
   localparam int PTR_BITS = IDX_BITS + 1;
   localparam int SUM_BITS = gov_pkg::STEP_BITS + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SRCH  = 4'd1;
   localparam logic [3:0] S_SWAIT = 4'd2;
   localparam logic [3:0] S_SDEC  = 4'd3;
   localparam logic [3:0] S_CLR   = 4'd4;
   localparam logic [3:0] S_SEED  = 4'd5;
   localparam logic [3:0] S_POP   = 4'd6;
   localparam logic [3:0] S_PWAIT = 4'd7;
   localparam logic [3:0] S_NB    = 4'd8;
   localparam logic [3:0] S_CHK   = 4'd9;
   localparam logic [3:0] S_LEG   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   // Configuration registers.
   logic [gov_pkg::DIM_REG_BITS-1:0] rows_reg_ff, cols_reg_ff;
   logic [CNT_BITS-1:0]              rows_c, cols_c;

   // Memories.
   logic [HEIGHT_BITS-1:0] grid_mem [DEPTH];
   logic                   vis_mem  [DEPTH];
   logic [IDX_BITS-1:0]    queue_mem[DEPTH];
   logic [HEIGHT_BITS-1:0] grid_rdata_ff;
   logic                   vis_rdata_ff;
   logic [IDX_BITS-1:0]    queue_rdata_ff;

   // Sequencer state.
   logic [3:0]            state_ff, state_in;
   logic [DIM_BITS-1:0]   srow_ff, srow_in, scol_ff, scol_in;
   logic                  sv_ff, sv_in;
   logic [IDX_BITS-1:0]   sidx_ff, sidx_in;
   logic                  found_ff, found_in;
   logic [HEIGHT_BITS-1:0] best_h_ff, best_h_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic                  first_ff, first_in;
   logic                  fail_ff, fail_in;
   logic [IDX_BITS-1:0]   cur_pos_ff, cur_pos_in;
   logic [HEIGHT_BITS-1:0] last_h_ff, last_h_in;
   logic [gov_pkg::STEP_BITS-1:0] total_ff, total_in;
   logic [IDX_BITS-1:0]   clr_ff, clr_in;
   logic [PTR_BITS-1:0]   head_ff, head_in, tail_ff, tail_in, lend_ff, lend_in;
   logic [PTR_BITS-1:0]   level_ff, level_in;
   logic [IDX_BITS-1:0]   p_ff, p_in;
   logic [1:0]            k_ff, k_in;
   logic [IDX_BITS-1:0]   q_ff, q_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gov_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Memory port controls.
   logic                   grid_we;
   logic [IDX_BITS-1:0]    grid_waddr, grid_raddr;
   logic [HEIGHT_BITS-1:0] grid_wdata;
   logic                   vis_we, vis_wdata;
   logic [IDX_BITS-1:0]    vis_waddr;
   logic                   queue_we;
   logic [IDX_BITS-1:0]    queue_waddr, queue_wdata;

   // Shared neighbor unit.
   logic [DIM_BITS-1:0] p_row, p_col, n_row, n_col;
   logic                n_inb;
   logic [IDX_BITS-1:0] n_idx;

   logic req_take, cfg_write, cand_ok;
   logic [SUM_BITS-1:0] sum_wide;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign req_take  = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      prdata = '0;
      unique case (paddr)
         gov_pkg::REG_GRID_ROWS: prdata = gov_pkg::DATA_BITS'(rows_reg_ff);
         gov_pkg::REG_GRID_COLS: prdata = gov_pkg::DATA_BITS'(cols_reg_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= gov_pkg::DIM_REG_BITS'(64);
         cols_reg_ff <= gov_pkg::DIM_REG_BITS'(64);
      end else if (cfg_write) begin
         if (paddr == gov_pkg::REG_GRID_ROWS) begin
            rows_reg_ff <= pwdata[gov_pkg::DIM_REG_BITS-1:0];
         end
         if (paddr == gov_pkg::REG_GRID_COLS) begin
            cols_reg_ff <= pwdata[gov_pkg::DIM_REG_BITS-1:0];
         end
      end
   end

   // Zero counts as one row or column; larger than the store saturates.
   always_comb begin
      if (rows_reg_ff == '0) rows_c = CNT_BITS'(1);
      else if (int'(rows_reg_ff) > MAX_DIM) rows_c = CNT_BITS'(MAX_DIM);
      else rows_c = CNT_BITS'(rows_reg_ff);
      if (cols_reg_ff == '0) cols_c = CNT_BITS'(1);
      else if (int'(cols_reg_ff) > MAX_DIM) cols_c = CNT_BITS'(MAX_DIM);
      else cols_c = CNT_BITS'(cols_reg_ff);
   end

   // The neighbor of the dequeued cell in direction k, with its bounds check.
   assign p_row = p_ff[IDX_BITS-1:DIM_BITS];
   assign p_col = p_ff[DIM_BITS-1:0];
   always_comb begin
      n_row = p_row;
      n_col = p_col;
      n_inb = 1'b0;
      case (k_ff)
         2'd0: begin
            n_col = p_col + DIM_BITS'(1);
            n_inb = ({1'b0, p_col} + CNT_BITS'(1)) < cols_c;
         end
         2'd1: begin
            n_col = p_col - DIM_BITS'(1);
            n_inb = (p_col != '0);
         end
         2'd2: begin
            n_row = p_row + DIM_BITS'(1);
            n_inb = ({1'b0, p_row} + CNT_BITS'(1)) < rows_c;
         end
         default: begin
            n_row = p_row - DIM_BITS'(1);
            n_inb = (p_row != '0);
         end
      endcase
      n_idx = {n_row, n_col};
   end

   // A cell of the search pass qualifies when it is a target later in the order.
   assign cand_ok = (grid_rdata_ff > HEIGHT_BITS'(1)) &&
                    (first_ff || (grid_rdata_ff > last_h_ff) ||
                     ((grid_rdata_ff == last_h_ff) && (sidx_ff > cur_pos_ff)));

   assign sum_wide = {1'b0, total_ff} + SUM_BITS'(level_ff);

   always_comb begin
      state_in     = state_ff;
      srow_in      = srow_ff;
      scol_in      = scol_ff;
      sv_in        = 1'b0;
      sidx_in      = {srow_ff, scol_ff};
      found_in     = found_ff;
      best_h_in    = best_h_ff;
      best_idx_in  = best_idx_ff;
      first_in     = first_ff;
      fail_in      = fail_ff;
      cur_pos_in   = cur_pos_ff;
      last_h_in    = last_h_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      lend_in      = lend_ff;
      level_in     = level_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;

      grid_we     = 1'b0;
      grid_waddr  = {DIM_BITS'(req_word.cell_row), DIM_BITS'(req_word.cell_col)};
      grid_wdata  = HEIGHT_BITS'(req_word.cell_value);
      grid_raddr  = (state_ff == S_SRCH) ? {srow_ff, scol_ff} : n_idx;
      vis_we      = 1'b0;
      vis_waddr   = q_ff;
      vis_wdata   = 1'b1;
      queue_we    = 1'b0;
      queue_waddr = tail_ff[IDX_BITS-1:0];
      queue_wdata = q_ff;

      // Running minimum over the streamed search reads; ties keep the earlier.
      if (sv_ff && cand_ok && (!found_ff || grid_rdata_ff < best_h_ff)) begin
         found_in    = 1'b1;
         best_h_in   = grid_rdata_ff;
         best_idx_in = sidx_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_word.action == gov_pkg::ACTION_LOAD) begin
                  grid_we = (int'(req_word.cell_row) < MAX_DIM) &&
                            (int'(req_word.cell_col) < MAX_DIM);
               end else begin
                  first_in   = 1'b1;
                  fail_in    = 1'b0;
                  cur_pos_in = '0;
                  last_h_in  = '0;
                  total_in   = '0;
                  srow_in    = '0;
                  scol_in    = '0;
                  found_in   = 1'b0;
                  state_in   = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            sv_in = 1'b1;
            if ({1'b0, scol_ff} == cols_c - CNT_BITS'(1)) begin
               scol_in = '0;
               if ({1'b0, srow_ff} == rows_c - CNT_BITS'(1)) begin
                  state_in = S_SWAIT;
               end else begin
                  srow_in = srow_ff + DIM_BITS'(1);
               end
            end else begin
               scol_in = scol_ff + DIM_BITS'(1);
            end
         end
         S_SWAIT: state_in = S_SDEC;
         S_SDEC: begin
            if (!found_ff) begin
               state_in = S_FIN;
            end else if (best_idx_ff == cur_pos_ff) begin
               level_in = '0;
               state_in = S_LEG;
            end else begin
               clr_in   = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            vis_wdata = 1'b0;
            clr_in    = clr_ff + IDX_BITS'(1);
            if (&clr_ff) state_in = S_SEED;
         end
         S_SEED: begin
            vis_we      = 1'b1;
            vis_waddr   = cur_pos_ff;
            queue_we    = 1'b1;
            queue_waddr = '0;
            queue_wdata = cur_pos_ff;
            head_in     = '0;
            tail_in     = PTR_BITS'(1);
            lend_in     = PTR_BITS'(1);
            level_in    = PTR_BITS'(1);
            state_in    = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               fail_in  = 1'b1;
               state_in = S_FIN;
            end else if (head_ff == lend_ff) begin
               level_in = level_ff + PTR_BITS'(1);
               lend_in  = tail_ff;
            end else begin
               head_in  = head_ff + PTR_BITS'(1);
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            p_in     = queue_rdata_ff;
            k_in     = '0;
            state_in = S_NB;
         end
         S_NB: begin
            if (n_inb) begin
               q_in     = n_idx;
               state_in = S_CHK;
            end else if (k_ff == 2'd3) begin
               state_in = S_POP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_CHK: begin
            state_in = (k_ff == 2'd3) ? S_POP : S_NB;
            k_in     = k_ff + 2'd1;
            if (grid_rdata_ff != '0 && !vis_rdata_ff) begin
               if (q_ff == best_idx_ff) begin
                  state_in = S_LEG;
               end else begin
                  vis_we   = 1'b1;
                  queue_we = 1'b1;
                  tail_in  = tail_ff + PTR_BITS'(1);
               end
            end
         end
         S_LEG: begin
            if (sum_wide[gov_pkg::STEP_BITS]) total_in = '1;
            else total_in = sum_wide[gov_pkg::STEP_BITS-1:0];
            cur_pos_in = best_idx_ff;
            last_h_in  = best_h_ff;
            first_in   = 1'b0;
            srow_in    = '0;
            scol_in    = '0;
            found_in   = 1'b0;
            state_in   = S_SRCH;
         end
         S_FIN: begin
            // The held result is only replaced once it has been taken.
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.walk_status = fail_ff ? gov_pkg::STATUS_UNREACHABLE
                                                 : gov_pkg::STATUS_OK;
               rsp_word_in.total_steps = fail_ff ? '0 : total_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sv_ff        <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      srow_ff     <= srow_in;
      scol_ff     <= scol_in;
      sidx_ff     <= sidx_in;
      found_ff    <= found_in;
      best_h_ff   <= best_h_in;
      best_idx_ff <= best_idx_in;
      first_ff    <= first_in;
      fail_ff     <= fail_in;
      cur_pos_ff  <= cur_pos_in;
      last_h_ff   <= last_h_in;
      total_ff    <= total_in;
      clr_ff      <= clr_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      lend_ff     <= lend_in;
      level_ff    <= level_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      q_ff        <= q_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
      grid_rdata_ff <= grid_mem[grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
      vis_rdata_ff <= vis_mem[n_idx];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
      queue_rdata_ff <= queue_mem[head_ff[IDX_BITS-1:0]];
   end

`ifndef SYNTH
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.walk_status == gov_pkg::STATUS_UNREACHABLE
      |-> rsp_word_ff.total_steps == '0)
      else $error("unreachable result carries a nonzero step count");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP || state_ff == S_NB || state_ff == S_CHK)
      |-> (head_ff <= tail_ff) && (lend_ff <= tail_ff))
      else $error("frontier queue pointers out of order");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_word.action == gov_pkg::ACTION_RUN |=> req_stall)
      else $error("block not busy after taking a run word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("held result changed while stalled");
`endif

endmodule

[test/gov_walk_checker.sv]
`timescale 1ns / 1ps
// Checker for the ordered grid walk: watches both word channels and the APB port.
// Depends on gov_pkg for word types and register addresses.
module gov_walk_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  gov_pkg::req_word_type         req_word,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  gov_pkg::rsp_word_type         rsp_word,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gov_pkg::ADDR_BITS-1:0] paddr,
   input  logic [gov_pkg::DATA_BITS-1:0] pwdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            result_count
);

   localparam int DIM = gov_pkg::MAX_DIM_DEFAULT;
   localparam int CELL_COUNT = DIM * DIM;
   localparam int REG_BITS = gov_pkg::DIM_REG_BITS;
   localparam int SBITS = gov_pkg::STEP_BITS;
   localparam longint STEP_LIMIT = (longint'(1) << SBITS) - 1;

   logic [15:0] height_mem [0:CELL_COUNT-1];
   bit          seen_mem   [0:CELL_COUNT-1];
   int          wave_q     [0:CELL_COUNT-1];
   logic [REG_BITS-1:0] rows_reg, cols_reg;
   gov_pkg::rsp_word_type pending_walks [$];
   int fails, results;

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) height_mem[i] = '0;
   end

   function automatic int clamp_dim(logic [REG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   // Breadth-first leg length over open cells, -1 when the target is walled off.
   function automatic int leg_steps(int src, int dst, int rows, int cols);
      int dr [4] = '{0, 0, 1, -1};
      int dc [4] = '{1, -1, 0, 0};
      int head, tail, stop, lvl, p, nr, nc, q;
      if (src == dst) return 0;
      for (int i = 0; i < CELL_COUNT; i++) seen_mem[i] = 0;
      head = 0;
      tail = 1;
      lvl = 0;
      wave_q[0] = src;
      seen_mem[src] = 1;
      while (head < tail) begin
         stop = tail;
         lvl++;
         while (head < stop) begin
            p = wave_q[head];
            head++;
            for (int k = 0; k < 4; k++) begin
               nr = p / DIM + dr[k];
               nc = p % DIM + dc[k];
               if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
               q = nr * DIM + nc;
               if (height_mem[q] == 0 || seen_mem[q]) continue;
               if (q == dst) return lvl;
               seen_mem[q] = 1;
               wave_q[tail] = q;
               tail++;
            end
         end
      end
      return -1;
   endfunction

   function automatic gov_pkg::rsp_word_type predict_walk();
      gov_pkg::rsp_word_type w;
      int rows, cols, here, last_h, best_i, best_h, idx, len;
      bit first, found;
      longint total;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      here = 0;
      last_h = 0;
      total = 0;
      first = 1;
      w.walk_status = gov_pkg::STATUS_OK;
      forever begin
         found = 0;
         best_i = 0;
         best_h = 0;
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               idx = r * DIM + c;
               if (height_mem[idx] <= 1) continue;
               if (!first && (height_mem[idx] < last_h ||
                              (height_mem[idx] == last_h && idx <= here))) continue;
               if (!found || height_mem[idx] < best_h) begin
                  found = 1;
                  best_h = height_mem[idx];
                  best_i = idx;
               end
            end
         end
         if (!found) break;
         len = leg_steps(here, best_i, rows, cols);
         if (len < 0) begin
            w.walk_status = gov_pkg::STATUS_UNREACHABLE;
            break;
         end
         total = total + len;
         if (total > STEP_LIMIT) total = STEP_LIMIT;
         here = best_i;
         last_h = best_h;
         first = 0;
      end
      w.total_steps = (w.walk_status == gov_pkg::STATUS_OK) ? total[SBITS-1:0] : '0;
      return w;
   endfunction

   always @(posedge clock) begin
      gov_pkg::rsp_word_type want;
      if (reset) begin
         rows_reg = REG_BITS'(DIM);
         cols_reg = REG_BITS'(DIM);
         pending_walks.delete();
         fails = 0;
         results = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == gov_pkg::REG_GRID_ROWS) rows_reg = pwdata[REG_BITS-1:0];
            else if (paddr == gov_pkg::REG_GRID_COLS) cols_reg = pwdata[REG_BITS-1:0];
         end
         if (req_valid && !req_stall) begin
            if (req_word.action == gov_pkg::ACTION_LOAD)
               height_mem[{req_word.cell_row, req_word.cell_col}] = req_word.cell_value;
            else
               pending_walks.insert(pending_walks.size(), predict_walk());
         end
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (pending_walks.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result word: status %0d steps %0d",
                           rsp_word.walk_status, rsp_word.total_steps);
            end else begin
               want = pending_walks.pop_front();
               if (want.walk_status !== rsp_word.walk_status ||
                   want.total_steps !== rsp_word.total_steps) begin
                  fails++;
                  if (fails <= 10)
                     $display("result mismatch: expected status %0d steps %0d, got %0d %0d",
                              want.walk_status, want.total_steps,
                              rsp_word.walk_status, rsp_word.total_steps);
               end
            end
         end
      end
      fail_count <= fails + pending_walks.size();
      result_count <= results;
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for grid_ordered_visit_path_length: clock, reset, stimulus, verdict.
// Depends on gov_pkg and on gov_walk_checker, which predicts and compares.
module tb_top;

   localparam int DIM = gov_pkg::MAX_DIM_DEFAULT;
   localparam int REQ_BITS = $bits(gov_pkg::req_word_type);
   // Cycles with no word and no register write moved before the run is declared hung.
   // A leg costs at most a clear of the visited memory plus the search, and an
   // area used here holds at most 128 targets.
   localparam int HANG_LIMIT = 3000000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   gov_pkg::req_word_type req_word;
   gov_pkg::rsp_word_type rsp_word;
   logic psel, penable, pwrite, pready;
   logic [gov_pkg::ADDR_BITS-1:0] paddr;
   logic [gov_pkg::DATA_BITS-1:0] pwdata, prdata;
   int fail_count, result_count;

   // Shadow of which cells have been loaded, so that a walk never reads a cell
   // that was never written, plus the active area as the block will see it.
   bit written_map [0:DIM*DIM-1];
   int act_rows, act_cols;
   int runs_sent, words_sent, idle_count;
   bit tight_send, tight_take;

   grid_ordered_visit_path_length dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   gov_walk_checker walk_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .result_count(result_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Watchdog: any accepted word or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= HANG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: stall a random number of cycles before each word, sometimes
   // in long stretches with no stall at all.
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         if ($urandom_range(0, 39) == 0) tight_take = !tight_take;
         n = tight_take ? 0 : $urandom_range(0, 14);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1;
         end
         @(negedge clock);
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // All tasks are entered and left just after a falling edge.
   task automatic send_word(input gov_pkg::req_word_type w);
      int gap;
      if ($urandom_range(0, 39) == 0) tight_send = !tight_send;
      gap = tight_send ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic load_cell(input int r, input int c, input logic [15:0] v);
      gov_pkg::req_word_type w;
      w.action = gov_pkg::ACTION_LOAD;
      w.cell_row = r[5:0];
      w.cell_col = c[5:0];
      w.cell_value = v;
      written_map[r * DIM + c] = 1;
      send_word(w);
   endtask

   // Height for a cell inside the area: mostly open, some walls, few targets.
   // Small heights come often so that equal heights are common.
   function automatic logic [15:0] pick_height(bit big_area);
      int d;
      d = $urandom_range(0, 99);
      if (big_area) return (d < 6) ? 16'd0 : 16'd1;
      if (d < 72) return 16'd1;
      if (d < 92) return 16'd0;
      if (d < 96) return 16'($urandom_range(2, 5));
      return 16'($urandom_range(2, 65535));
   endfunction

   // A walk reads every active cell, so any cell never loaded is loaded first.
   task automatic run_walk();
      gov_pkg::req_word_type w;
      for (int r = 0; r < act_rows; r++)
         for (int c = 0; c < act_cols; c++)
            if (!written_map[r * DIM + c])
               load_cell(r, c, pick_height(act_rows * act_cols > 64));
      w = REQ_BITS'($urandom());
      w.action = gov_pkg::ACTION_RUN;
      runs_sent++;
      send_word(w);
   endtask

   // Waits until every walk has answered, then lets the block drain.
   task automatic settle();
      req_valid <= 0;
      while (result_count != runs_sent) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(input logic [gov_pkg::ADDR_BITS-1:0] a, input int v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= a;
      pwdata <= v;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   // Register values 0 and above 64 are folded the same way the block folds them.
   task automatic set_area(input int rv, input int cv);
      csr_write(gov_pkg::REG_GRID_ROWS, rv);
      csr_write(gov_pkg::REG_GRID_COLS, cv);
      act_rows = (rv == 0) ? 1 : (rv > DIM) ? DIM : rv;
      act_cols = (cv == 0) ? 1 : (cv > DIM) ? DIM : cv;
   endtask

   // One phase of random traffic: loads with random content, a walk now and
   // then, and stray loads anywhere in the store that reach every address bit.
   task automatic random_phase(input int count);
      int r, c;
      repeat (count) begin
         if ($urandom_range(0, 29) == 0) begin
            run_walk();
         end else if ($urandom_range(0, 99) < 85) begin
            r = $urandom_range(0, act_rows - 1);
            c = $urandom_range(0, act_cols - 1);
            load_cell(r, c, pick_height(0));
         end else begin
            load_cell($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                      16'($urandom_range(0, 1)));
         end
      end
      run_walk();
      settle();
   endtask

   initial begin
      int rv, cv;
      reset = 1;
      req_valid = 0;
      req_word = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      tight_send = 0;
      tight_take = 0;
      runs_sent = 0;
      words_sent = 0;
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part on a 3x4 area: an empty walk, a target on the start cell,
      // equal heights, the widest height, a walled start cell, and a target
      // that cannot be reached.
      set_area(3, 4);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 4; c++)
            load_cell(r, c, 16'd1);
      run_walk();
      load_cell(0, 0, 16'd3);
      load_cell(2, 3, 16'd3);
      load_cell(1, 1, 16'd0);
      load_cell(0, 3, 16'hFFFF);
      run_walk();
      load_cell(0, 0, 16'd0);
      run_walk();
      load_cell(1, 3, 16'd0);
      load_cell(2, 2, 16'd0);
      run_walk();
      settle();

      // Random phases on small areas, register value zero among them.
      while (words_sent < 1250) begin
         rv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
         cv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
         set_area(rv, cv);
         random_phase($urandom_range(30, 80));
      end

      // Full-length rows and columns: register values above the limit
      // saturate to a whole column or a whole row, then the exact limit on a
      // two-row strip with its far corner as a target.
      set_area(127, 0);
      random_phase(20);
      set_area(0, 127);
      random_phase(20);
      set_area(2, 64);
      load_cell(1, DIM - 1, 16'd9);
      run_walk();
      load_cell(0, DIM - 1, 16'd0);
      load_cell(1, DIM - 2, 16'd0);
      run_walk();
      settle();

      if (fail_count == 0 && result_count == runs_sent)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
